// ----- src/qtg_pkg.sv -----
package qtg_pkg;

    // Number format and limits.
    localparam int FRAC_BITS  = 16;
    localparam int MAX_POINTS = 64;
    localparam int DW         = 48;
    localparam int WW         = 56;
    localparam int KW         = $clog2(MAX_POINTS);
    localparam int TK_W       = 32 + KW;
    localparam int DIV_W      = DW + FRAC_BITS;

    typedef logic signed [DW-1:0] t_q48;
    typedef logic signed [WW-1:0] t_wide;

    localparam t_q48 Q48_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam t_q48 Q48_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam t_wide S32_MAX = t_wide'(64'sh7FFF_FFFF);
    localparam t_wide S32_MIN = -S32_MAX - t_wide'(1);

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_FRAME  = 2'd1,
        STATUS_POINTS = 2'd2
    } t_status;

    // Sequencer states.
    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_CHECK,
        SQ_ISSUE,
        SQ_WAIT,
        SQ_EMIT
    } t_state;

    // Steps of the fit and of one sample, in issue order.
    typedef enum logic [4:0] {
        ST_T2, ST_B1, ST_B2, ST_B3A, ST_B3B, ST_B4A, ST_B4B, ST_B5A, ST_B5B,
        ST_S, ST_TS,
        ST_P4, ST_P3, ST_P2, ST_P1, ST_P0,
        ST_D4, ST_D3, ST_D2, ST_D1,
        ST_E4, ST_E3, ST_E2,
        ST_V, ST_A1, ST_A2
    } t_step;

    typedef struct packed {
        logic start;
        t_q48 a;
        t_q48 b;
        logic sh17;
    } t_mul_req;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [31:0]      den;
        logic             neg;
    } t_div_req;

    typedef struct packed {
        logic done;
        t_q48 value;
    } t_res;

    function automatic t_q48 sat48(input t_wide x);
        if (x > t_wide'(Q48_MAX)) return Q48_MAX;
        if (x < t_wide'(Q48_MIN)) return Q48_MIN;
        return x[DW-1:0];
    endfunction

    function automatic logic signed [31:0] sat32(input t_wide x);
        if (x > S32_MAX) return 32'sh7FFF_FFFF;
        if (x < S32_MIN) return 32'sh8000_0000;
        return x[31:0];
    endfunction

    function automatic t_q48 sadd(input t_q48 a, input t_q48 b);
        return sat48(t_wide'(a) + t_wide'(b));
    endfunction

    function automatic t_q48 sneg(input t_q48 a);
        return sat48(-t_wide'(a));
    endfunction

    function automatic t_q48 smulk(input t_q48 a, input logic signed [5:0] k);
        return sat48(t_wide'(a) * t_wide'(k));
    endfunction

    function automatic logic [DW-1:0] mag48(input t_q48 x);
        return x[DW-1] ? DW'(-x) : DW'(x);
    endfunction

endpackage

// ----- src/qtg_mul.sv -----
module qtg_mul (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  qtg_pkg::t_mul_req i_req,
    output qtg_pkg::t_res    o_res
);

    localparam int DW = qtg_pkg::DW;
    localparam int H  = DW / 2;
    localparam int PW = 2 * DW;
    localparam logic [2:0] LAST_CNT = 3'd4;
    localparam logic [PW:0] M_POS = (PW+1)'(qtg_pkg::Q48_MAX);
    localparam logic [PW:0] M_NEG = M_POS + (PW+1)'(1);

    logic          r_busy, r_done, r_neg, r_sh17;
    logic [2:0]    r_cnt;
    logic [DW-1:0] r_ma, r_mb;
    logic [PW-1:0] r_acc;
    qtg_pkg::t_q48 r_res;

    logic [H-1:0]  pa, pb;
    logic [DW-1:0] pp;
    logic [PW-1:0] pp_sh;
    logic [PW:0]   rnd, rsum, m;
    qtg_pkg::t_q48 fin;

    // One half-by-half partial product per cycle.
    always_comb begin
        pa    = r_ma[H-1:0];
        pb    = r_mb[H-1:0];
        pp_sh = '0;
        case (r_cnt)
            3'd1: begin pb = r_mb[DW-1:H]; end
            3'd2: begin pa = r_ma[DW-1:H]; end
            3'd3: begin pa = r_ma[DW-1:H]; pb = r_mb[DW-1:H]; end
            default: begin end
        endcase
        pp = pa * pb;
        case (r_cnt)
            3'd0:       pp_sh = PW'(pp);
            3'd1, 3'd2: pp_sh = PW'(pp) << H;
            3'd3:       pp_sh = PW'(pp) << DW;
            default:    pp_sh = '0;
        endcase
    end

    // Round half away from zero on the magnitude, then saturate with the sign.
    always_comb begin
        rnd  = r_sh17 ? ((PW+1)'(1) << qtg_pkg::FRAC_BITS)
                      : ((PW+1)'(1) << (qtg_pkg::FRAC_BITS - 1));
        rsum = {1'b0, r_acc} + rnd;
        m    = r_sh17 ? (rsum >> (qtg_pkg::FRAC_BITS + 1)) : (rsum >> qtg_pkg::FRAC_BITS);
        if (r_neg) begin
            fin = (m > M_NEG) ? qtg_pkg::Q48_MIN : -qtg_pkg::t_q48'(m[DW-1:0]);
        end else begin
            fin = (m > M_POS) ? qtg_pkg::Q48_MAX : qtg_pkg::t_q48'(m[DW-1:0]);
        end
    end

    // Control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == LAST_CNT) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 3'd1;
                end
            end
        end
    end

    // Operands, accumulator and result.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_ma   <= qtg_pkg::mag48(i_req.a);
            r_mb   <= qtg_pkg::mag48(i_req.b);
            r_neg  <= i_req.a[DW-1] ^ i_req.b[DW-1];
            r_sh17 <= i_req.sh17;
            r_acc  <= '0;
        end else if (r_busy) begin
            if (r_cnt == LAST_CNT) begin
                r_res <= fin;
            end else begin
                r_acc <= r_acc + pp_sh;
            end
        end
    end

    assign o_res = '{done: r_done, value: r_res};

endmodule

// ----- src/qtg_div.sv -----
module qtg_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  qtg_pkg::t_div_req i_req,
    output qtg_pkg::t_res     o_res
);

    localparam int DW    = qtg_pkg::DW;
    localparam int DIV_W = qtg_pkg::DIV_W;
    localparam int CW    = $clog2(DIV_W + 1);
    localparam logic [CW-1:0] STEPS = CW'(DIV_W);
    localparam logic [DW:0] Q_POS   = (DW+1)'(qtg_pkg::Q48_MAX);
    localparam logic [DW:0] Q_CLAMP = Q_POS + (DW+1)'(1);

    logic             r_busy, r_done, r_neg, r_over;
    logic [CW-1:0]    r_cnt;
    logic [DIV_W-1:0] r_num;
    logic [31:0]      r_den, r_rem;
    logic [DW:0]      r_q;
    qtg_pkg::t_q48    r_res;

    logic [32:0]   rem_sh;
    logic          ge;
    logic [31:0]   rem_n;
    logic [DW:0]   q_sh;
    qtg_pkg::t_q48 fin;

    // One quotient bit per cycle, restoring.
    always_comb begin
        rem_sh = {r_rem, r_num[DIV_W-1]};
        ge     = rem_sh >= {1'b0, r_den};
        rem_n  = ge ? 32'(rem_sh - {1'b0, r_den}) : rem_sh[31:0];
        q_sh   = {r_q[DW-1:0], ge};
        if (r_neg) begin
            fin = (r_over || r_q > Q_CLAMP) ? qtg_pkg::Q48_MIN
                                            : -qtg_pkg::t_q48'(r_q[DW-1:0]);
        end else begin
            fin = (r_over || r_q > Q_POS) ? qtg_pkg::Q48_MAX
                                          : qtg_pkg::t_q48'(r_q[DW-1:0]);
        end
    end

    // Control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == STEPS) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + CW'(1);
                end
            end
        end
    end

    // Dividend shift, remainder and quotient; the quotient clamps once it overflows.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num  <= i_req.num;
            r_den  <= i_req.den;
            r_neg  <= i_req.neg;
            r_rem  <= '0;
            r_q    <= '0;
            r_over <= 1'b0;
        end else if (r_busy) begin
            if (r_cnt == STEPS) begin
                r_res <= fin;
            end else begin
                r_num <= r_num << 1;
                r_rem <= rem_n;
                if (q_sh > Q_CLAMP) begin
                    r_q    <= Q_CLAMP;
                    r_over <= 1'b1;
                end else begin
                    r_q <= q_sh;
                end
            end
        end
    end

    assign o_res = '{done: r_done, value: r_res};

endmodule

// ----- src/quintic_trajectory_generator_core.sv -----
// Quintic trajectory generator. Each request beat carries a time frame, the start and
// end position, velocity and acceleration, and a point count; the core fits the quintic
// that meets those six conditions and streams point_count evenly spaced samples of
// time, position, velocity and acceleration (signed Q16.16, saturated), with tlast on
// the final one. Point counts above 64 are treated as 64. A frame whose end is not after
// its start, or fewer than two points, gives a single beat with an error status in tuser,
// zero data and tlast. All arithmetic runs through one sequential multiplier and one
// bit-serial divider under a step sequencer, and each sample needs five divisions. The
// input is ready only while the core is idle; a result beat may wait in the output
// register while the next sample is computed.
module quintic_trajectory_generator_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // start_time, end_time, point_count, start_pos, start_vel, start_acc,
    // end_pos, end_vel, end_acc; bit 263 must be zero (the core does not check it)
    input  logic [263:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // sample_time, position, velocity, acceleration
    output logic [127:0] m_axis_tdata,
    // status
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast
);

    localparam int DW   = qtg_pkg::DW;
    localparam int KW   = qtg_pkg::KW;
    localparam int TK_W = qtg_pkg::TK_W;
    localparam logic [6:0] MAXP = 7'(qtg_pkg::MAX_POINTS);

    qtg_pkg::t_state r_state, n_state;
    qtg_pkg::t_step  r_step;

    logic                 r_bad_frame, r_bad_pts;
    logic [KW-1:0]        r_k, r_nm1;
    logic signed [31:0]   r_t0, r_ts;
    logic [31:0]          r_T;
    logic [TK_W-1:0]      r_tk;
    qtg_pkg::t_q48        r_q0, r_v0, r_a0, r_vf, r_af, r_h;
    qtg_pkg::t_q48        r_t2, r_b1, r_b2, r_b3, r_b4, r_b5, r_x;
    qtg_pkg::t_q48        r_s, r_p, r_d, r_e, r_v, r_a;

    logic                 r_ovalid, r_olast;
    logic [127:0]         r_odata;
    logic [1:0]           r_ouser;

    qtg_pkg::t_mul_req mul_req;
    qtg_pkg::t_div_req div_req;
    qtg_pkg::t_res     mul_res, div_res;

    logic          in_acc, can_load, is_div, unit_done, issue, last_smp;
    logic          load_err, load_smp;
    qtg_pkg::t_q48 res, t_ext;

    // Input fields.
    logic signed [31:0] in_t0, in_t1, in_q0, in_v0, in_a0, in_qf, in_vf, in_af;
    logic [6:0]         in_n, in_ncl;

    assign in_t0 = s_axis_tdata[31:0];
    assign in_t1 = s_axis_tdata[63:32];
    assign in_n  = s_axis_tdata[70:64];
    assign in_q0 = s_axis_tdata[102:71];
    assign in_v0 = s_axis_tdata[134:103];
    assign in_a0 = s_axis_tdata[166:135];
    assign in_qf = s_axis_tdata[198:167];
    assign in_vf = s_axis_tdata[230:199];
    assign in_af = s_axis_tdata[262:231];
    assign in_ncl = (in_n > MAXP) ? MAXP : in_n;

    assign s_axis_tready = (r_state == qtg_pkg::SQ_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign can_load      = !r_ovalid || m_axis_tready;
    assign last_smp      = (r_k == r_nm1);
    assign t_ext         = {{(DW-32){1'b0}}, r_T};

    // Division steps go to the divider, all other steps to the multiplier.
    always_comb begin
        case (r_step)
            qtg_pkg::ST_S, qtg_pkg::ST_TS, qtg_pkg::ST_V,
            qtg_pkg::ST_A1, qtg_pkg::ST_A2: is_div = 1'b1;
            default:                        is_div = 1'b0;
        endcase
    end

    assign unit_done = is_div ? div_res.done : mul_res.done;
    assign res       = is_div ? div_res.value : mul_res.value;

    // Sequencer: next state and strobes.
    always_comb begin
        n_state  = r_state;
        issue    = 1'b0;
        load_err = 1'b0;
        load_smp = 1'b0;
        case (r_state)
            qtg_pkg::SQ_IDLE: begin
                if (in_acc) n_state = qtg_pkg::SQ_CHECK;
            end
            qtg_pkg::SQ_CHECK: begin
                if (r_bad_frame || r_bad_pts) begin
                    if (can_load) begin
                        load_err = 1'b1;
                        n_state  = qtg_pkg::SQ_IDLE;
                    end
                end else begin
                    n_state = qtg_pkg::SQ_ISSUE;
                end
            end
            qtg_pkg::SQ_ISSUE: begin
                issue   = 1'b1;
                n_state = qtg_pkg::SQ_WAIT;
            end
            qtg_pkg::SQ_WAIT: begin
                if (unit_done) begin
                    n_state = (r_step == qtg_pkg::ST_A2) ? qtg_pkg::SQ_EMIT : qtg_pkg::SQ_ISSUE;
                end
            end
            qtg_pkg::SQ_EMIT: begin
                if (can_load) begin
                    load_smp = 1'b1;
                    n_state  = last_smp ? qtg_pkg::SQ_IDLE : qtg_pkg::SQ_ISSUE;
                end
            end
            default: n_state = qtg_pkg::SQ_IDLE;
        endcase
    end

    // Multiplier operands for each step.
    always_comb begin
        mul_req.start = issue && !is_div;
        mul_req.sh17  = 1'b0;
        mul_req.a     = r_p;
        mul_req.b     = r_s;
        case (r_step)
            qtg_pkg::ST_T2: begin mul_req.a = t_ext; mul_req.b = t_ext; end
            qtg_pkg::ST_B1: begin mul_req.a = r_v0; mul_req.b = t_ext; end
            qtg_pkg::ST_B2: begin mul_req.a = r_a0; mul_req.b = r_t2; mul_req.sh17 = 1'b1; end
            qtg_pkg::ST_B3A: begin
                mul_req.a = qtg_pkg::sadd(qtg_pkg::smulk(r_v0, 6'sd6),
                                          qtg_pkg::smulk(r_vf, 6'sd4));
                mul_req.b = t_ext;
            end
            qtg_pkg::ST_B3B: begin
                mul_req.a = qtg_pkg::sadd(qtg_pkg::smulk(r_a0, 6'sd3), qtg_pkg::sneg(r_af));
                mul_req.b = r_t2;
                mul_req.sh17 = 1'b1;
            end
            qtg_pkg::ST_B4A: begin
                mul_req.a = qtg_pkg::sadd(qtg_pkg::smulk(r_v0, 6'sd8),
                                          qtg_pkg::smulk(r_vf, 6'sd7));
                mul_req.b = t_ext;
            end
            qtg_pkg::ST_B4B: begin
                mul_req.a = qtg_pkg::sadd(qtg_pkg::smulk(r_a0, 6'sd3),
                                          qtg_pkg::smulk(r_af, -6'sd2));
                mul_req.b = r_t2;
                mul_req.sh17 = 1'b1;
            end
            qtg_pkg::ST_B5A: begin
                mul_req.a = qtg_pkg::smulk(qtg_pkg::sadd(r_v0, r_vf), 6'sd3);
                mul_req.b = t_ext;
            end
            qtg_pkg::ST_B5B: begin
                mul_req.a = qtg_pkg::sadd(r_af, qtg_pkg::sneg(r_a0));
                mul_req.b = r_t2;
                mul_req.sh17 = 1'b1;
            end
            qtg_pkg::ST_D4, qtg_pkg::ST_D3, qtg_pkg::ST_D2, qtg_pkg::ST_D1: begin
                mul_req.a = r_d;
            end
            qtg_pkg::ST_E4, qtg_pkg::ST_E3, qtg_pkg::ST_E2: begin
                mul_req.a = r_e;
            end
            default: begin end
        endcase
    end

    // Divider operands for each step.
    always_comb begin
        div_req.start = issue && is_div;
        div_req.neg   = 1'b0;
        div_req.den   = r_T;
        div_req.num   = qtg_pkg::DIV_W'(qtg_pkg::mag48(r_e)) << qtg_pkg::FRAC_BITS;
        case (r_step)
            qtg_pkg::ST_S: begin
                div_req.num = qtg_pkg::DIV_W'(r_k) << qtg_pkg::FRAC_BITS;
                div_req.den = 32'(r_nm1);
            end
            qtg_pkg::ST_TS: begin
                div_req.num = qtg_pkg::DIV_W'(r_tk);
                div_req.den = 32'(r_nm1);
            end
            qtg_pkg::ST_V: begin
                div_req.num = qtg_pkg::DIV_W'(qtg_pkg::mag48(r_d)) << qtg_pkg::FRAC_BITS;
                div_req.neg = r_d[DW-1];
            end
            default: begin
                div_req.neg = r_e[DW-1];
            end
        endcase
    end

    qtg_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_res   (mul_res)
    );

    qtg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_res   (div_res)
    );

    // State, step and sample counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qtg_pkg::SQ_IDLE;
            r_step  <= qtg_pkg::ST_T2;
            r_k     <= '0;
            r_tk    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == qtg_pkg::SQ_CHECK) begin
                r_step <= qtg_pkg::ST_T2;
                r_k    <= '0;
                r_tk   <= '0;
            end else if (r_state == qtg_pkg::SQ_WAIT && unit_done &&
                         r_step != qtg_pkg::ST_A2) begin
                r_step <= qtg_pkg::t_step'(5'(r_step) + 5'd1);
            end else if (load_smp) begin
                r_step <= qtg_pkg::ST_S;
                if (!last_smp) begin
                    r_k  <= r_k + KW'(1);
                    r_tk <= r_tk + TK_W'(r_T);
                end
            end
        end
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_bad_frame <= (in_t1 <= in_t0);
            r_bad_pts   <= (in_n < 7'd2);
            r_nm1       <= KW'(in_ncl - 7'd1);
            r_t0        <= in_t0;
            r_T         <= 32'(in_t1 - in_t0);
            r_q0        <= DW'(in_q0);
            r_v0        <= DW'(in_v0);
            r_a0        <= DW'(in_a0);
            r_vf        <= DW'(in_vf);
            r_af        <= DW'(in_af);
            r_h         <= DW'(in_qf) - DW'(in_q0);
        end
    end

    // Result write-back of each step.
    always_ff @(posedge i_clk) begin
        if (r_state == qtg_pkg::SQ_WAIT && unit_done) begin
            case (r_step)
                qtg_pkg::ST_T2:  r_t2 <= res;
                qtg_pkg::ST_B1:  r_b1 <= res;
                qtg_pkg::ST_B2:  r_b2 <= res;
                qtg_pkg::ST_B3A: r_x  <= qtg_pkg::sadd(qtg_pkg::smulk(r_h, 6'sd10),
                                                       qtg_pkg::sneg(res));
                qtg_pkg::ST_B3B: r_b3 <= qtg_pkg::sadd(r_x, qtg_pkg::sneg(res));
                qtg_pkg::ST_B4A: r_x  <= qtg_pkg::sadd(qtg_pkg::smulk(r_h, -6'sd15), res);
                qtg_pkg::ST_B4B: r_b4 <= qtg_pkg::sadd(r_x, res);
                qtg_pkg::ST_B5A: r_x  <= qtg_pkg::sadd(qtg_pkg::smulk(r_h, 6'sd6),
                                                       qtg_pkg::sneg(res));
                qtg_pkg::ST_B5B: r_b5 <= qtg_pkg::sadd(r_x, res);
                qtg_pkg::ST_S: begin
                    r_s <= res;
                    r_p <= r_b5;
                    r_d <= qtg_pkg::smulk(r_b5, 6'sd5);
                    r_e <= qtg_pkg::smulk(r_b5, 6'sd20);
                end
                qtg_pkg::ST_TS:  r_ts <= qtg_pkg::sat32(qtg_pkg::t_wide'(r_t0) +
                                                        qtg_pkg::t_wide'(res));
                qtg_pkg::ST_P4:  r_p <= qtg_pkg::sadd(res, r_b4);
                qtg_pkg::ST_P3:  r_p <= qtg_pkg::sadd(res, r_b3);
                qtg_pkg::ST_P2:  r_p <= qtg_pkg::sadd(res, r_b2);
                qtg_pkg::ST_P1:  r_p <= qtg_pkg::sadd(res, r_b1);
                qtg_pkg::ST_P0:  r_p <= qtg_pkg::sadd(res, r_q0);
                qtg_pkg::ST_D4:  r_d <= qtg_pkg::sadd(res, qtg_pkg::smulk(r_b4, 6'sd4));
                qtg_pkg::ST_D3:  r_d <= qtg_pkg::sadd(res, qtg_pkg::smulk(r_b3, 6'sd3));
                qtg_pkg::ST_D2:  r_d <= qtg_pkg::sadd(res, qtg_pkg::smulk(r_b2, 6'sd2));
                qtg_pkg::ST_D1:  r_d <= qtg_pkg::sadd(res, r_b1);
                qtg_pkg::ST_E4:  r_e <= qtg_pkg::sadd(res, qtg_pkg::smulk(r_b4, 6'sd12));
                qtg_pkg::ST_E3:  r_e <= qtg_pkg::sadd(res, qtg_pkg::smulk(r_b3, 6'sd6));
                qtg_pkg::ST_E2:  r_e <= qtg_pkg::sadd(res, qtg_pkg::smulk(r_b2, 6'sd2));
                qtg_pkg::ST_V:   r_v <= res;
                qtg_pkg::ST_A1:  r_e <= res;
                qtg_pkg::ST_A2:  r_a <= res;
                default: begin end
            endcase
        end
    end

    // Output register: holds one beat while the next sample is computed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load_err || load_smp) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_err) begin
            r_odata <= '0;
            r_ouser <= r_bad_frame ? qtg_pkg::STATUS_FRAME : qtg_pkg::STATUS_POINTS;
            r_olast <= 1'b1;
        end else if (load_smp) begin
            r_odata <= {qtg_pkg::sat32(qtg_pkg::t_wide'(r_a)),
                        qtg_pkg::sat32(qtg_pkg::t_wide'(r_v)),
                        qtg_pkg::sat32(qtg_pkg::t_wide'(r_p)),
                        r_ts};
            r_ouser <= qtg_pkg::STATUS_OK;
            r_olast <= last_smp;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;
    assign m_axis_tlast  = r_olast;

    // The two arithmetic units are never started together.
    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mul_req.start && div_req.start))
        else $error("multiplier and divider started together");

    // The sample index never passes the last sample.
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == qtg_pkg::SQ_ISSUE || r_state == qtg_pkg::SQ_WAIT ||
         r_state == qtg_pkg::SQ_EMIT) |-> r_k <= r_nm1)
        else $error("sample index beyond point count");

    // An error beat is a single, zero, final beat.
    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != qtg_pkg::STATUS_OK) |->
        (m_axis_tlast && m_axis_tdata == '0))
        else $error("error beat not final or not zero");

    // A request is taken only once; the core is busy right after it.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !s_axis_tready)
        else $error("input ready right after a request");

endmodule
